>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round-constant table for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] src;
    logic       init;
    logic       round;
    logic       add;
    logic       out_adv;
    logic       clear;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
    logic       word_last;
  } sha_sts_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> design/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: block shift register, message schedule, round logic and chain.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::sha_cmd_t   cmd,
  input  logic [7:0]          in_byte,
  output sha_pkg::sha_sts_t   sts,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index
);
  import sha_pkg::*;

  logic [511:0] blk_r, blk_nxt;
  logic [255:0] vars_r, vars_nxt;
  logic [255:0] chain_r, chain_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [2:0]   widx_r, widx_nxt;
  logic [7:0]   push_byte;
  logic [31:0]  w, w_new, a, b, c, d, e, f, g, h, t1, t2, s0_w, s1_w;

  assign w = blk_r[511:480];
  assign {a, b, c, d, e, f, g, h} = vars_r;

  always_comb begin
    s0_w  = rotr(blk_r[479:448], 7) ^ rotr(blk_r[479:448], 18) ^ (blk_r[479:448] >> 3);
    s1_w  = rotr(blk_r[63:32], 17) ^ rotr(blk_r[63:32], 19) ^ (blk_r[63:32] >> 10);
    w_new = s1_w + blk_r[223:192] + s0_w + w;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + K_TAB[rnd_r] + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    case (cmd.src)
      SRC_DATA: push_byte = in_byte;
      SRC_PAD:  push_byte = 8'h80;
      SRC_ZERO: push_byte = 8'h00;
      default:  push_byte = bits_r[{3'd7 - pos_r[2:0], 3'd0} +: 8];
    endcase
  end

  always_comb begin
    blk_nxt   = blk_r;
    vars_nxt  = vars_r;
    chain_nxt = chain_r;
    bits_nxt  = bits_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    if (cmd.push) begin
      blk_nxt = {blk_r[503:0], push_byte};
      pos_nxt = pos_r + 6'd1;
      if (cmd.src == SRC_DATA) begin
        bits_nxt = bits_r + 64'd8;
      end
    end
    if (cmd.init) begin
      vars_nxt = chain_r;
      rnd_nxt  = '0;
    end
    if (cmd.round) begin
      blk_nxt  = {blk_r[479:0], w_new};
      vars_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
      rnd_nxt  = rnd_r + 6'd1;
    end
    if (cmd.add) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i*32 +: 32] = chain_r[i*32 +: 32] + vars_r[i*32 +: 32];
      end
    end
    if (cmd.out_adv) begin
      widx_nxt = widx_r + 3'd1;
    end
    if (cmd.clear) begin
      chain_nxt = IV;
      bits_nxt  = '0;
      pos_nxt   = '0;
      widx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (!rst_n) begin
      vars_r  <= '0;
      chain_r <= IV;
      bits_r  <= '0;
      pos_r   <= '0;
      rnd_r   <= '0;
      widx_r  <= '0;
    end else begin
      vars_r  <= vars_nxt;
      chain_r <= chain_nxt;
      bits_r  <= bits_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
    end
  end

  assign sts.pos        = pos_r;
  assign sts.round_last = (rnd_r == 6'd63);
  assign sts.word_last  = (widx_r == 3'd7);
  assign digest_word    = chain_r[{3'd7 - widx_r, 5'd0} +: 32];
  assign word_index     = widx_r;

endmodule

>>> design/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: absorbs bytes, sequences padding, compression and output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_has_byte,
  input  logic              in_eom,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sha_pkg::sha_sts_t sts,
  output sha_pkg::sha_cmd_t cmd
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_PAD80  = 3'd4;
  localparam logic [2:0] S_PADZ   = 3'd5;
  localparam logic [2:0] S_PADLEN = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.push = 1'b1;
            cmd.src  = SRC_DATA;
          end
          if (in_has_byte && sts.pos == 6'd63) begin
            state_nxt = S_INIT;
            ret_nxt   = in_eom ? S_PAD80 : S_IDLE;
          end else if (in_eom) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ret_r;
      end
      S_PAD80: begin
        cmd.push  = 1'b1;
        cmd.src   = SRC_PAD;
        state_nxt = S_PADZ;
        if (sts.pos == 6'd63) begin
          state_nxt = S_INIT;
          ret_nxt   = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.pos == 6'd56) begin
          state_nxt = S_PADLEN;
        end else begin
          cmd.push = 1'b1;
          cmd.src  = SRC_ZERO;
          if (sts.pos == 6'd63) begin
            state_nxt = S_INIT;
            ret_nxt   = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
        if (sts.pos == 6'd63) begin
          state_nxt = S_INIT;
          ret_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_adv = 1'b1;
          if (sts.word_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

>>> design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 digest of a byte stream, eight digest words per message.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata                          | tuser    | tlast
// in_     | slave     | data_byte                      | has_byte | end_of_message
// out_    | master    | digest_word, word_index, zeros | -        | last_word
//
// A message byte is taken whenever in_tready is high; the 64th byte of a block
// starts the one-round-per-cycle compression, with setup and chain update.
// The final transaction is followed by the padding bytes, a step that pushes
// nothing, the length bytes and one or two compressions before the eight
// digest words, which stall on out_tready.
// Reset is synchronous; in_tready is low while a block is compressed or output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zeros
  output logic        out_tlast
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_has_byte(in_tuser), .in_eom(in_tlast),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .sts, .cmd
  );

  sha_dp u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_tdata), .sts,
    .digest_word, .word_index
  );

  assign out_tdata = {5'd0, word_index, digest_word};
  assign out_tlast = sts.word_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input accepted during output");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[34:32] == 3'd7))
    else $error("last word index");
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("no return to idle");

endmodule
